// ----- src/mlq_pkg.sv -----
// Package for the multilevel queue scheduler: sizes, operation and event codes,
// and the payload types of the request and response channels. No dependencies.
`default_nettype none
package mlq_pkg;

  localparam int DEF_NUM_LEVELS  = 16;
  localparam int DEF_NUM_DEVICES = 8;
  localparam int DEF_MAX_TASKS   = 64;
  localparam logic [3:0] DEF_PROMOTE_INTERVAL = 4'd5;

  // Operation codes on the request channel.
  localparam logic [1:0] FN_ADMIT = 2'd0;
  localparam logic [1:0] FN_RUN   = 2'd1;
  localparam logic [1:0] FN_IO    = 2'd2;
  localparam logic [1:0] FN_NONE  = 2'd3;

  // Event codes on the response channel.
  localparam logic [3:0] EV_ADMITTED = 4'd0;
  localparam logic [3:0] EV_FULL     = 4'd1;
  localparam logic [3:0] EV_PROMOTED = 4'd2;
  localparam logic [3:0] EV_IDLE     = 4'd3;
  localparam logic [3:0] EV_REQUEUED = 4'd4;
  localparam logic [3:0] EV_TO_DEV   = 4'd5;
  localparam logic [3:0] EV_FINISHED = 4'd6;
  localparam logic [3:0] EV_RETURNED = 4'd7;
  localparam logic [3:0] EV_DEV_EMPTY = 4'd8;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] level;
    logic [2:0] burst_time;
    logic       go_io;
    logic [2:0] device;
  } mlq_req_t;

  typedef struct packed {
    logic [3:0] event_res;
    logic [5:0] task_id;
    logic [3:0] served_level;
    logic [2:0] device_used;
    logic [2:0] remaining;
  } mlq_rsp_t;

  // Write enables of the three slot memories.
  typedef struct packed {
    logic link_we;
    logic home_we;
    logic time_we;
  } slot_we_t;

endpackage
`default_nettype wire

// ----- src/mlq_ifs.sv -----
// Channel interfaces of the multilevel queue scheduler: request, response and
// configuration write. Depends on mlq_pkg for the payload types.
`default_nettype none
interface mlq_req_if;
  logic              valid;
  logic              ready;
  mlq_pkg::mlq_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mlq_rsp_if;
  logic              valid;
  logic              ready;
  mlq_pkg::mlq_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mlq_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/multilevel_queue_scheduler_top.sv -----
// Top level of the multilevel queue scheduler: request/response channels,
// queue-pointer memory and sequencer. Depends on mlq_pkg, mlq_ifs, mlq_slot_store.
`default_nettype none
// Tasks sit in linked FIFO lists: one list per priority level, one per device
// and a free list of recycled slots. Queue heads and tails live in one
// synchronous memory and the per-slot link, home level and time left in
// three more, so each list operation is a short read-modify-write sequence. One
// request is worked at a time; a result waits in an output register so the
// next request is taken while it is still pending. The steps of each
// operation are set by the single read and write port of the queue-pointer
// memory and its registered read. No clearing pass runs after reset; the busy
// flags of the lists are cleared at once.
module multilevel_queue_scheduler_top #(
  parameter int NUM_LEVELS  = mlq_pkg::DEF_NUM_LEVELS,
  parameter int NUM_DEVICES = mlq_pkg::DEF_NUM_DEVICES,
  parameter int MAX_TASKS   = mlq_pkg::DEF_MAX_TASKS
) (
  input wire logic clk,
  input wire logic rst,
  mlq_req_if.sink   req,
  mlq_rsp_if.source rsp,
  mlq_cfg_if.sink   cfg
);
  import mlq_pkg::*;

  localparam int SW = $clog2(MAX_TASKS);
  localparam int LW = $clog2(NUM_LEVELS);
  localparam int QN = NUM_LEVELS + NUM_DEVICES + 1;
  localparam int QW = $clog2(QN);
  localparam int FW = $clog2(MAX_TASKS + 1);
  localparam int PW = $clog2(NUM_LEVELS + 1);
  localparam logic [QW-1:0] FREE_Q = QW'(NUM_LEVELS + NUM_DEVICES);

  typedef enum logic [11:0] {
    ST_IDLE       = 12'b000000000001,
    ST_POP_RD     = 12'b000000000010,
    ST_POP_H      = 12'b000000000100,
    ST_POP_S      = 12'b000000001000,
    ST_PUSH_RD    = 12'b000000010000,
    ST_PUSH_W     = 12'b000000100000,
    ST_ADMIT_W    = 12'b000001000000,
    ST_PROMO      = 12'b000010000000,
    ST_PROMO_PUSH = 12'b000100000000,
    ST_RUN_UPD    = 12'b001000000000,
    ST_IO_UPD     = 12'b010000000000,
    ST_DONE       = 12'b100000000000
  } state_t;

  state_t state, ret;

  // Control and working registers.
  logic [QN-1:0] qbusy;
  logic [FW-1:0] fresh_cnt;
  logic [3:0]    slot_cnt;
  logic [3:0]    interval;
  logic [PW-1:0] promo_idx;
  logic [QW-1:0] pq, push_q;
  logic [SW-1:0] slot, push_slot, pop_tail;
  logic          pop_last;
  logic [LW-1:0] pop_home;
  logic [2:0]    pop_time;
  logic [LW-1:0] op_lvl;
  logic [2:0]    op_burst;
  logic          op_go;
  logic [2:0]    op_dev;
  logic          op_dev_ok;
  mlq_rsp_t      res;
  mlq_rsp_t      rsp_data;
  logic          rsp_valid;

  // Queue-pointer memory.
  logic [SW-1:0] head_mem [QN];
  logic [SW-1:0] tail_mem [QN];
  logic [QW-1:0] q_raddr, q_waddr;
  logic [SW-1:0] q_rhead, q_rtail, q_whead, q_wtail;
  logic          q_we;

  // Slot memory signals.
  slot_we_t      s_we;
  logic [SW-1:0] s_link_waddr, s_link_wdata, s_ht_waddr;
  logic [LW-1:0] s_home_wdata;
  logic [2:0]    s_time_wdata;
  logic [SW-1:0] s_link, s_raddr;
  logic [LW-1:0] s_home;
  logic [2:0]    s_time;

  // Request decode.
  logic [LW-1:0] lvl_sat;
  logic [2:0]    burst_fix;
  logic          dev_ok;
  logic [QW-1:0] dev_q;
  logic          dev_busy;
  logic          any_ready;
  logic [LW-1:0] served;
  logic [2:0]    rem;

  assign req.ready = (state == ST_IDLE) && !rst;
  assign cfg.ready = !rst;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  always_comb begin
    lvl_sat   = (32'(req.data.level) >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1)
                                                    : LW'(req.data.level);
    burst_fix = (req.data.burst_time == 3'd0) ? 3'd1 : req.data.burst_time;
    dev_ok    = 32'(req.data.device) < NUM_DEVICES;
    dev_q     = QW'(NUM_LEVELS) + QW'(req.data.device);
    dev_busy  = dev_ok && qbusy[dev_q];
    rem       = pop_time - 3'd1;
  end

  // Lowest-numbered non-empty level.
  always_comb begin
    any_ready = 1'b0;
    served    = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (qbusy[i]) begin
        any_ready = 1'b1;
        served    = LW'(i);
      end
    end
  end

  // Queue-pointer memory access for the current step.
  always_comb begin
    q_raddr = (state == ST_PUSH_RD) ? push_q : pq;
    q_we    = 1'b0;
    q_waddr = pq;
    q_whead = s_link;
    q_wtail = pop_tail;
    if (state == ST_POP_S && !pop_last) begin
      q_we = 1'b1;
    end else if (state == ST_PUSH_W) begin
      q_we    = 1'b1;
      q_waddr = push_q;
      q_whead = qbusy[push_q] ? q_rhead : push_slot;
      q_wtail = push_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      head_mem[q_waddr] <= q_whead;
      tail_mem[q_waddr] <= q_wtail;
    end
    q_rhead <= head_mem[q_raddr];
    q_rtail <= tail_mem[q_raddr];
  end

  // Slot memory access for the current step.
  always_comb begin
    s_we         = '0;
    s_link_waddr = q_rtail;
    s_link_wdata = push_slot;
    s_ht_waddr   = slot;
    s_home_wdata = op_lvl;
    s_time_wdata = op_burst;
    s_raddr      = q_rhead;
    if (state == ST_PUSH_W && qbusy[push_q]) begin
      s_we.link_we = 1'b1;
    end
    if (state == ST_ADMIT_W) begin
      s_we.home_we = 1'b1;
      s_we.time_we = 1'b1;
    end
    if (state == ST_RUN_UPD) begin
      s_we.time_we = 1'b1;
      s_time_wdata = rem;
    end
  end

  mlq_slot_store #(.SW(SW), .LW(LW)) u_slots (
    .clk        (clk),
    .we         (s_we),
    .link_waddr (s_link_waddr),
    .link_wdata (s_link_wdata),
    .ht_waddr   (s_ht_waddr),
    .home_wdata (s_home_wdata),
    .time_wdata (s_time_wdata),
    .raddr      (s_raddr),
    .link_rdata (s_link),
    .home_rdata (s_home),
    .time_rdata (s_time)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret       <= ST_IDLE;
      qbusy     <= '0;
      fresh_cnt <= '0;
      slot_cnt  <= '0;
      interval  <= DEF_PROMOTE_INTERVAL;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg.valid) interval <= cfg.data;
      if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            op_lvl    <= lvl_sat;
            op_burst  <= burst_fix;
            op_go     <= req.data.go_io;
            op_dev    <= req.data.device;
            op_dev_ok <= dev_ok;
            res       <= '0;
            case (req.data.func)
              FN_ADMIT: begin
                if (qbusy[FREE_Q]) begin
                  pq    <= FREE_Q;
                  ret   <= ST_ADMIT_W;
                  state <= ST_POP_RD;
                end else if (fresh_cnt < FW'(MAX_TASKS)) begin
                  slot      <= SW'(fresh_cnt);
                  fresh_cnt <= fresh_cnt + FW'(1);
                  state     <= ST_ADMIT_W;
                end else begin
                  res.event_res    <= EV_FULL;
                  res.served_level <= 4'(lvl_sat);
                  state            <= ST_DONE;
                end
              end
              FN_RUN: begin
                if (slot_cnt == interval) begin
                  slot_cnt  <= 4'd1;
                  promo_idx <= PW'(1);
                  state     <= ST_PROMO;
                end else if (!any_ready) begin
                  res.event_res <= EV_IDLE;
                  state         <= ST_DONE;
                end else begin
                  slot_cnt <= slot_cnt + 4'd1;
                  op_lvl   <= served;
                  pq       <= QW'(served);
                  ret      <= ST_RUN_UPD;
                  state    <= ST_POP_RD;
                end
              end
              FN_IO: begin
                if (!dev_busy) begin
                  res.event_res   <= EV_DEV_EMPTY;
                  res.device_used <= req.data.device;
                  state           <= ST_DONE;
                end else begin
                  pq    <= dev_q;
                  ret   <= ST_IO_UPD;
                  state <= ST_POP_RD;
                end
              end
              default: state <= ST_IDLE;
            endcase
          end
        end

        // Pop the head of list pq into slot.
        ST_POP_RD: state <= ST_POP_H;
        ST_POP_H: begin
          slot     <= q_rhead;
          pop_tail <= q_rtail;
          pop_last <= (q_rhead == q_rtail);
          if (q_rhead == q_rtail) qbusy[pq] <= 1'b0;
          state <= ST_POP_S;
        end
        ST_POP_S: begin
          pop_home <= s_home;
          pop_time <= s_time;
          state    <= ret;
        end

        // Append push_slot to list push_q.
        ST_PUSH_RD: state <= ST_PUSH_W;
        ST_PUSH_W: begin
          qbusy[push_q] <= 1'b1;
          state         <= ret;
        end

        ST_ADMIT_W: begin
          push_q           <= QW'(op_lvl);
          push_slot        <= slot;
          res.event_res    <= EV_ADMITTED;
          res.task_id      <= 6'(slot);
          res.served_level <= 4'(op_lvl);
          res.remaining    <= op_burst;
          ret              <= ST_DONE;
          state            <= ST_PUSH_RD;
        end

        // Promotion pass over levels 1 and up.
        ST_PROMO: begin
          if (promo_idx == PW'(NUM_LEVELS)) begin
            res.event_res <= EV_PROMOTED;
            state         <= ST_DONE;
          end else if (qbusy[QW'(promo_idx)]) begin
            pq    <= QW'(promo_idx);
            ret   <= ST_PROMO_PUSH;
            state <= ST_POP_RD;
          end else begin
            promo_idx <= promo_idx + PW'(1);
          end
        end
        ST_PROMO_PUSH: begin
          push_q    <= QW'(promo_idx - PW'(1));
          push_slot <= slot;
          promo_idx <= promo_idx + PW'(1);
          ret       <= ST_PROMO;
          state     <= ST_PUSH_RD;
        end

        // Served task: finish, requeue or move to a device.
        ST_RUN_UPD: begin
          push_slot        <= slot;
          res.task_id      <= 6'(slot);
          res.served_level <= 4'(op_lvl);
          res.remaining    <= rem;
          if (rem == 3'd0) begin
            push_q        <= FREE_Q;
            res.event_res <= EV_FINISHED;
          end else if (!op_go || !op_dev_ok) begin
            push_q        <= QW'(pop_home);
            res.event_res <= EV_REQUEUED;
          end else begin
            push_q          <= QW'(NUM_LEVELS) + QW'(op_dev);
            res.event_res   <= EV_TO_DEV;
            res.device_used <= op_dev;
          end
          ret   <= ST_DONE;
          state <= ST_PUSH_RD;
        end

        ST_IO_UPD: begin
          push_q           <= QW'(pop_home);
          push_slot        <= slot;
          res.event_res    <= EV_RETURNED;
          res.task_id      <= 6'(slot);
          res.served_level <= 4'(pop_home);
          res.device_used  <= op_dev;
          res.remaining    <= pop_time;
          ret              <= ST_DONE;
          state            <= ST_PUSH_RD;
        end

        // Hand the result to the output register once it is free.
        ST_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_data  <= res;
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Fresh slots are never handed out beyond the task capacity.
  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh_cnt <= FW'(MAX_TASKS))
    else $error("fresh slot count beyond capacity");

  // A pop only starts on a list that holds a task.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP_RD) |-> qbusy[pq])
    else $error("pop from an empty list");

  // A valid operation leaves the idle state.
  a_op_starts: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.data.func != FN_NONE) |=> (state != ST_IDLE))
    else $error("accepted operation was dropped");

  // A result appears only when the sequencer hands one over.
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_DONE))
    else $error("response raised outside the result step");
`endif

endmodule
`default_nettype wire

// ----- src/mlq_slot_store.sv -----
// Per-task slot storage: link to the next slot, home level and time left.
// Three synchronous memories with registered reads; uses mlq_pkg.
`default_nettype none
module mlq_slot_store #(
  parameter int SW = 6,
  parameter int LW = 4
) (
  input  wire logic              clk,
  input  wire mlq_pkg::slot_we_t we,
  input  wire logic [SW-1:0]     link_waddr,
  input  wire logic [SW-1:0]     link_wdata,
  input  wire logic [SW-1:0]     ht_waddr,
  input  wire logic [LW-1:0]     home_wdata,
  input  wire logic [2:0]        time_wdata,
  input  wire logic [SW-1:0]     raddr,
  output logic      [SW-1:0]     link_rdata,
  output logic      [LW-1:0]     home_rdata,
  output logic      [2:0]        time_rdata
);
  import mlq_pkg::*;

  localparam int DEPTH = 1 << SW;

  logic [SW-1:0] link_mem [DEPTH];
  logic [LW-1:0] home_mem [DEPTH];
  logic [2:0]    time_mem [DEPTH];

  // Writes, each memory with its own enable.
  always_ff @(posedge clk) begin
    if (we.link_we) link_mem[link_waddr] <= link_wdata;
    if (we.home_we) home_mem[ht_waddr] <= home_wdata;
    if (we.time_we) time_mem[ht_waddr] <= time_wdata;
  end

  // Registered reads at one shared address.
  always_ff @(posedge clk) begin
    link_rdata <= link_mem[raddr];
    home_rdata <= home_mem[raddr];
    time_rdata <= time_mem[raddr];
  end

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Testbench for the multilevel queue scheduler: directed and random requests,
// a behavioral scheduler that predicts each response, and a field-by-field check.
// Depends on mlq_pkg, the mlq channel interfaces and multilevel_queue_scheduler_top.
`timescale 1ns / 1ps
module tb_top;
  import mlq_pkg::*;

  localparam int NLEV = DEF_NUM_LEVELS;
  localparam int NDEV = DEF_NUM_DEVICES;
  localparam int NSLOT = DEF_MAX_TASKS;
  localparam int FREE_LIST = NLEV + NDEV;
  localparam int NLISTS = NLEV + NDEV + 1;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mlq_req_if req_ch ();
  mlq_rsp_if rsp_ch ();
  mlq_cfg_if cfg_ch ();

  multilevel_queue_scheduler_top dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Scheduler shadow state: levels, then devices, then the free list.
  logic [5:0] list_head [NLISTS];
  logic [5:0] list_tail [NLISTS];
  bit         list_busy [NLISTS];
  logic [5:0] link_of [NSLOT];
  logic [3:0] home_of [NSLOT];
  logic [2:0] time_of [NSLOT];
  int         fresh_slots;
  logic [3:0] run_count;
  logic [3:0] interval_reg;

  mlq_req_t pending_reqs[$];
  mlq_rsp_t expected_rsps[$];
  int       failures = 0;
  bit       req_taken = 1'b0;
  bit       rsp_taken = 1'b0;

  function automatic void list_push(int q, logic [5:0] s);
    if (list_busy[q]) link_of[list_tail[q]] = s;
    else list_head[q] = s;
    list_tail[q] = s;
    list_busy[q] = 1'b1;
  endfunction

  function automatic logic [5:0] list_pop(int q);
    logic [5:0] s;
    s = list_head[q];
    if (s == list_tail[q]) list_busy[q] = 1'b0;
    else list_head[q] = link_of[s];
    return s;
  endfunction

  // Computes the response to one request and updates the shadow state.
  function automatic mlq_rsp_t schedule_step(mlq_req_t r);
    mlq_rsp_t o;
    logic [5:0] s;
    logic [2:0] burst;
    logic [2:0] rem;
    int served;
    o = '0;
    burst = (r.burst_time == 3'd0) ? 3'd1 : r.burst_time;
    case (r.func)
      FN_ADMIT: begin
        if (list_busy[FREE_LIST]) begin
          s = list_pop(FREE_LIST);
        end else if (fresh_slots < NSLOT) begin
          s = fresh_slots[5:0];
          fresh_slots++;
        end else begin
          o.event_res = EV_FULL;
          o.served_level = r.level;
          return o;
        end
        home_of[s] = r.level;
        time_of[s] = burst;
        list_push(r.level, s);
        o.event_res = EV_ADMITTED;
        o.task_id = s;
        o.served_level = r.level;
        o.remaining = burst;
      end
      FN_RUN: begin
        if (run_count == interval_reg) begin
          for (int i = 1; i < NLEV; i++) begin
            if (list_busy[i]) list_push(i - 1, list_pop(i));
          end
          run_count = 4'd1;
          o.event_res = EV_PROMOTED;
          return o;
        end
        served = NLEV;
        for (int i = NLEV - 1; i >= 0; i--) begin
          if (list_busy[i]) served = i;
        end
        if (served == NLEV) begin
          o.event_res = EV_IDLE;
          return o;
        end
        run_count = run_count + 4'd1;
        s = list_pop(served);
        rem = time_of[s] - 3'd1;
        time_of[s] = rem;
        o.task_id = s;
        o.served_level = served[3:0];
        if (rem == 3'd0) begin
          list_push(FREE_LIST, s);
          o.event_res = EV_FINISHED;
        end else if (!r.go_io || r.device >= NDEV) begin
          list_push(home_of[s], s);
          o.event_res = EV_REQUEUED;
          o.remaining = rem;
        end else begin
          list_push(NLEV + r.device, s);
          o.event_res = EV_TO_DEV;
          o.device_used = r.device;
          o.remaining = rem;
        end
      end
      default: begin
        o.device_used = r.device;
        if (r.device >= NDEV || !list_busy[NLEV + r.device]) begin
          o.event_res = EV_DEV_EMPTY;
          return o;
        end
        s = list_pop(NLEV + r.device);
        list_push(home_of[s], s);
        o.event_res = EV_RETURNED;
        o.task_id = s;
        o.served_level = home_of[s];
        o.remaining = time_of[s];
      end
    endcase
    return o;
  endfunction

  function automatic mlq_req_t make_req(logic [1:0] f, int lvl, int burst, bit io, int dev);
    mlq_req_t r;
    r.func = f;
    r.level = lvl[3:0];
    r.burst_time = burst[2:0];
    r.go_io = io;
    r.device = dev[2:0];
    return r;
  endfunction

  // Random request; weights are percentages of admit and run, the rest is
  // device completion with an occasional unused operation.
  function automatic mlq_req_t random_req(int admit_pct, int run_pct);
    int pick;
    logic [1:0] f;
    pick = $urandom_range(99);
    if (pick < admit_pct) f = FN_ADMIT;
    else if (pick < admit_pct + run_pct) f = FN_RUN;
    else if (pick < 98) f = FN_IO;
    else f = FN_NONE;
    return make_req(f, $urandom_range(15), $urandom_range(7), $urandom_range(1),
                    $urandom_range(7));
  endfunction

  // Request driver: changes at the falling edge, random gap before each item.
  int req_gap = 0;
  int calm_left = 0;
  always @(negedge clk) begin
    bit       nxt_valid;
    mlq_req_t nxt_data;
    nxt_valid = req_ch.valid;
    nxt_data = req_ch.data;
    if (rst) begin
      nxt_valid = 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      nxt_valid = 1'b0;
      if (req_gap > 0) begin
        req_gap--;
      end else if (pending_reqs.size() > 0) begin
        nxt_data = pending_reqs.pop_front();
        nxt_valid = 1'b1;
        // Alternate stretches of back-to-back traffic with random gaps.
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(39) == 0) calm_left = $urandom_range(10, 40);
        req_gap = (calm_left > 0) ? 0 : $urandom_range(19);
      end
    end
    req_ch.valid <= nxt_valid;
    req_ch.data <= nxt_data;
  end

  // Response stall generator.
  int rsp_wait = 0;
  always @(negedge clk) begin
    if (rsp_taken) rsp_wait = (calm_left > 0) ? 0 : $urandom_range(19);
    if (rsp_wait > 0) begin
      rsp_wait--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= !rst;
    end
  end

  // Monitor: checks each response transaction and predicts on each request other than FN_NONE.
  always @(posedge clk) begin
    mlq_rsp_t want;
    mlq_rsp_t got;
    req_taken <= req_ch.valid && req_ch.ready && !rst;
    rsp_taken <= rsp_ch.valid && rsp_ch.ready && !rst;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (expected_rsps.size() == 0) begin
        $error("response with none expected: %p", got);
        failures++;
      end else begin
        want = expected_rsps.pop_front();
        if (got.event_res !== want.event_res) begin
          $error("event_res expected %0d got %0d", want.event_res, got.event_res);
          failures++;
        end
        if (got.task_id !== want.task_id) begin
          $error("task_id expected %0d got %0d", want.task_id, got.task_id);
          failures++;
        end
        if (got.served_level !== want.served_level) begin
          $error("served_level expected %0d got %0d", want.served_level, got.served_level);
          failures++;
        end
        if (got.device_used !== want.device_used) begin
          $error("device_used expected %0d got %0d", want.device_used, got.device_used);
          failures++;
        end
        if (got.remaining !== want.remaining) begin
          $error("remaining expected %0d got %0d", want.remaining, got.remaining);
          failures++;
        end
      end
    end
    if (!rst && req_ch.valid && req_ch.ready && req_ch.data.func != FN_NONE)
      expected_rsps.push_back(schedule_step(req_ch.data));
  end

  // Watchdog on cycles without any transaction.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(logic [3:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    interval_reg = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(int n, int admit_pct, int run_pct);
    repeat (n) pending_reqs.push_back(random_req(admit_pct, run_pct));
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    for (int i = 0; i < NLISTS; i++) begin
      list_busy[i] = 1'b0;
      list_head[i] = '0;
      list_tail[i] = '0;
    end
    for (int i = 0; i < NSLOT; i++) begin
      link_of[i] = '0;
      home_of[i] = '0;
      time_of[i] = '0;
    end
    fresh_slots = 0;
    run_count = '0;
    interval_reg = DEF_PROMOTE_INTERVAL;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: field extremes, each operation, empty device, promotion.
    pending_reqs.push_back(make_req(FN_RUN, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(FN_IO, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(FN_ADMIT, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(FN_ADMIT, 15, 7, 1, 7));
    pending_reqs.push_back(make_req(FN_ADMIT, 7, 3, 0, 0));
    pending_reqs.push_back(make_req(FN_NONE, 15, 7, 1, 7));
    pending_reqs.push_back(make_req(FN_RUN, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(FN_RUN, 0, 0, 1, 7));
    pending_reqs.push_back(make_req(FN_RUN, 0, 0, 1, 0));
    pending_reqs.push_back(make_req(FN_IO, 0, 0, 0, 7));
    pending_reqs.push_back(make_req(FN_IO, 15, 7, 1, 0));
    pending_reqs.push_back(make_req(FN_RUN, 0, 0, 0, 3));
    pending_reqs.push_back(make_req(FN_RUN, 0, 0, 1, 5));
    pending_reqs.push_back(make_req(FN_ADMIT, 0, 1, 0, 0));
    pending_reqs.push_back(make_req(FN_RUN, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(FN_RUN, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(FN_RUN, 0, 0, 1, 2));
    pending_reqs.push_back(make_req(FN_IO, 0, 0, 0, 5));
    pending_reqs.push_back(make_req(FN_IO, 0, 0, 0, 2));
    repeat (5) pending_reqs.push_back(make_req(FN_RUN, 0, 0, 0, 0));
    wait_drained();

    write_interval(4'd1);
    random_phase(300, 65, 25);
    wait_drained();
    write_interval(4'd15);
    random_phase(300, 35, 45);
    wait_drained();
    write_interval(4'd0);
    random_phase(250, 15, 65);
    wait_drained();
    write_interval(4'd7);
    random_phase(300, 35, 45);
    wait_drained();
    write_interval(4'($urandom_range(1, 15)));
    random_phase(250, 50, 35);
    wait_drained();

    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
